/* design/raid5_degraded_block_read_assert.svh */
// ----------------------------------------------------------------------------
// raid5_degraded_block_read assertion macros
// Shorthand for clocked implication checks, reset-gated on arst_n.
// ----------------------------------------------------------------------------
`ifndef RAID5_DEGRADED_BLOCK_READ_ASSERT_SVH
`define RAID5_DEGRADED_BLOCK_READ_ASSERT_SVH

// same-cycle implication
`define R5DBR_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("r5dbr check failed");

// next-cycle implication
`define R5DBR_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("r5dbr check failed");

`endif

/* design/r5dbr_pkg.sv */
// ----------------------------------------------------------------------------
// r5dbr_pkg
// Shared constants, register indexes, sequencer states and divider bundles.
// ----------------------------------------------------------------------------
package r5dbr_pkg;

	// default geometry of the disk store
	localparam int MAX_DISKS_DEF      = 16;
	localparam int WORDS_PER_DISK_DEF = 4096;

	// shared divider width: covers stripe width (13 x 5 bits) and 16-bit blocks
	localparam int DIV_W = 18;

	// configuration port
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_NUM_DISKS     = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STRIPE_BLOCKS = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DISK_WORDS    = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PRESENT_MASK  = 4'd3;

	localparam logic [4:0]  NUM_DISKS_RST     = 5'd3;
	localparam logic [12:0] STRIPE_BLOCKS_RST = 13'd1;
	localparam logic [12:0] DISK_WORDS_RST    = 13'd4096;
	localparam logic [15:0] PRESENT_MASK_RST  = 16'hFFFF;

	// query sequencer
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SETUP,
		ST_GATE,
		ST_STRIPE,
		ST_COLUMN,
		ST_ROTATE,
		ST_SUB,
		ST_DISK,
		ST_OFFSET,
		ST_PLAN,
		ST_WALK,
		ST_DRAIN
	} seq_state_t;

	// divider request / response
	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quot;
		logic [DIV_W-1:0] rem;
	} div_rsp_t;

endpackage

/* design/r5dbr_div.sv */
// ----------------------------------------------------------------------------
// r5dbr_div
// Shared restoring divider, one quotient bit per cycle, DIV_W steps.
// ----------------------------------------------------------------------------
module r5dbr_div (
	input  logic                clk,
	input  logic                arst_n,
	input  r5dbr_pkg::div_req_t req,
	output r5dbr_pkg::div_rsp_t rsp
);

	localparam int W     = r5dbr_pkg::DIV_W;
	localparam int CNT_W = $clog2(W + 1);

	logic             run_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [W-1:0]     quot_q;
	logic [W-1:0]     rem_q;
	logic [W-1:0]     divisor_q;
	logic [W:0]       shifted;
	logic [W:0]       diff;
	logic             fits;

	// one restoring step
	assign shifted = {rem_q, quot_q[W-1]};
	assign fits    = shifted >= {1'b0, divisor_q};
	assign diff    = shifted - {1'b0, divisor_q};

	// step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient shifts in from the dividend, remainder builds up
	always_ff @(posedge clk) begin
		if (req.start) begin
			quot_q    <= req.dividend;
			rem_q     <= '0;
			divisor_q <= req.divisor;
		end else if (run_q) begin
			quot_q <= {quot_q[W-2:0], fits};
			rem_q  <= fits ? diff[W-1:0] : shifted[W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;
	assign rsp.rem  = rem_q;

endmodule

/* design/r5dbr_store.sv */
// ----------------------------------------------------------------------------
// r5dbr_store
// Single-port disk word memory with registered read data.
// ----------------------------------------------------------------------------
module r5dbr_store #(
	parameter int DEPTH = r5dbr_pkg::MAX_DISKS_DEF * r5dbr_pkg::WORDS_PER_DISK_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic          re,
	input  logic [AW-1:0] addr,
	input  logic [31:0]   wdata,
	output logic [31:0]   rdata
);

	logic [31:0] mem_q [DEPTH];
	logic [31:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* design/raid5_degraded_block_read.sv */
// ----------------------------------------------------------------------------
// raid5_degraded_block_read
// RAID5 left-symmetric block read with XOR rebuild of one missing disk.
// ----------------------------------------------------------------------------
// A load request (kind 0) writes one word to the disk store in the cycle it
// is accepted and leaves busy low. A query request (kind 1) holds busy high
// while one shared 18-step divider runs five times (stripe, column,
// rotation, sub-block, disk). It then reads the word from its disk when that
// disk is present, rebuilds it by walking the disks when it is missing, and
// reads nothing when the word offset falls past the disk end. Range,
// geometry or missing-disk checks reject a query before the divider runs.
// The result appears on done/ok/data, done high for exactly one cycle, in
// the cycle busy drops; it cannot be held off, so the receiver must take it
// then. A new request may be accepted in that same cycle. Configuration
// writes are always ready and are meant for idle periods only.
// ----------------------------------------------------------------------------
module raid5_degraded_block_read #(
	parameter int MAX_DISKS      = r5dbr_pkg::MAX_DISKS_DEF,
	parameter int WORDS_PER_DISK = r5dbr_pkg::WORDS_PER_DISK_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// request
	input  logic                             start,
	output logic                             busy,
	input  logic                             kind,
	input  logic [3:0]                       disk_index,
	input  logic [11:0]                      word_offset,
	input  logic [31:0]                      load_word,
	input  logic [15:0]                      block_number,
	// result
	output logic                             done,
	output logic                             ok,
	output logic [31:0]                      data,
	// configuration
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [r5dbr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [r5dbr_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int DEPTH = MAX_DISKS * WORDS_PER_DISK;
	localparam int AW    = $clog2(DEPTH);
	localparam int DW    = r5dbr_pkg::DIV_W;

	// configuration registers
	logic [4:0]  num_disks_q;
	logic [12:0] stripe_blocks_q;
	logic [12:0] disk_words_q;
	logic [15:0] present_mask_q;

	// sequencer
	r5dbr_pkg::seq_state_t state_q, state_d;
	r5dbr_pkg::div_req_t   div_req;
	r5dbr_pkg::div_rsp_t   div_rsp;

	// query datapath
	logic [15:0] block_q;
	logic [17:0] cap_q;
	logic [17:0] circle_q;
	logic        bad_q;
	logic [12:0] dwe_q;
	logic [15:0] stripe_q;
	logic [15:0] r_q;
	logic [15:0] col_q;
	logic [4:0]  rot_q;
	logic [12:0] sub_q;
	logic [4:0]  disk_q;
	logic [16:0] off_q;
	logic [4:0]  walk_q;
	logic [31:0] acc_q;
	logic        take_s1;

	// result registers
	logic        done_q;
	logic        ok_q;
	logic [31:0] data_q;

	// combinational helpers
	logic        accept;
	logic        load_ok;
	logic [4:0]  nm1;
	logic        n_bad;
	logic [12:0] dwe;
	logic [15:0] pres_in;
	logic [4:0]  pres_cnt;
	logic [4:0]  missing;
	logic [17:0] cap;
	logic [17:0] circle;
	logic [28:0] off_prod;
	logic        pres_disk;
	logic        pres_walk;
	logic        rd_en;
	logic        fin;
	logic        fin_ok;
	logic [31:0] acc_d;
	logic [31:0] rdata;
	logic [4:0]  rd_disk;
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr;

	assign accept    = start && !busy;
	assign busy      = (state_q != r5dbr_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_disks_q     <= r5dbr_pkg::NUM_DISKS_RST;
			stripe_blocks_q <= r5dbr_pkg::STRIPE_BLOCKS_RST;
			disk_words_q    <= r5dbr_pkg::DISK_WORDS_RST;
			present_mask_q  <= r5dbr_pkg::PRESENT_MASK_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				r5dbr_pkg::REG_NUM_DISKS:     num_disks_q     <= cfg_data[4:0];
				r5dbr_pkg::REG_STRIPE_BLOCKS: stripe_blocks_q <= cfg_data[12:0];
				r5dbr_pkg::REG_DISK_WORDS:    disk_words_q    <= cfg_data[12:0];
				r5dbr_pkg::REG_PRESENT_MASK:  present_mask_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// geometry checks, evaluated in SETUP
	assign nm1   = num_disks_q - 5'd1;
	assign n_bad = (num_disks_q < 5'd2) || (32'(num_disks_q) > MAX_DISKS)
		|| (stripe_blocks_q == 13'd0);
	assign dwe   = (32'(disk_words_q) > WORDS_PER_DISK) ? 13'(WORDS_PER_DISK)
		: disk_words_q;

	always_comb begin
		for (int i = 0; i < 16; i++) begin
			pres_in[i] = present_mask_q[i] && (5'(i) < num_disks_q);
		end
	end

	assign pres_cnt = 5'($countones(pres_in));
	assign missing  = num_disks_q - pres_cnt;
	assign cap      = 18'(nm1) * 18'(dwe);
	assign circle   = 18'(nm1) * 18'(stripe_blocks_q);
	assign off_prod = 29'(stripe_q) * 29'(stripe_blocks_q);

	// disk presence; mask bits above 15 read as missing
	assign pres_disk = (disk_q < 5'd16) && present_mask_q[disk_q[3:0]];
	assign pres_walk = (walk_q < 5'd16) && present_mask_q[walk_q[3:0]];

	assign acc_d = acc_q ^ (take_s1 ? rdata : 32'd0);

	// sequencer next state and control
	always_comb begin
		state_d          = state_q;
		div_req.start    = 1'b0;
		div_req.dividend = '0;
		div_req.divisor  = '0;
		rd_en            = 1'b0;
		fin              = 1'b0;
		fin_ok           = 1'b0;
		case (state_q)
			r5dbr_pkg::ST_IDLE: begin
				if (accept && kind) begin
					state_d = r5dbr_pkg::ST_SETUP;
				end
			end
			r5dbr_pkg::ST_SETUP: begin
				state_d = r5dbr_pkg::ST_GATE;
			end
			r5dbr_pkg::ST_GATE: begin
				if (bad_q || ({2'b00, block_q} >= cap_q)) begin
					fin     = 1'b1;
					state_d = r5dbr_pkg::ST_IDLE;
				end else begin
					// stripe = block / circle
					div_req.start    = 1'b1;
					div_req.dividend = DW'(block_q);
					div_req.divisor  = DW'(circle_q);
					state_d          = r5dbr_pkg::ST_STRIPE;
				end
			end
			r5dbr_pkg::ST_STRIPE: begin
				if (div_rsp.done) begin
					// column = (block mod circle) / (n - 1)
					div_req.start    = 1'b1;
					div_req.dividend = div_rsp.rem;
					div_req.divisor  = DW'(nm1);
					state_d          = r5dbr_pkg::ST_COLUMN;
				end
			end
			r5dbr_pkg::ST_COLUMN: begin
				if (div_rsp.done) begin
					// rotation = stripe mod n
					div_req.start    = 1'b1;
					div_req.dividend = DW'(stripe_q);
					div_req.divisor  = DW'(num_disks_q);
					state_d          = r5dbr_pkg::ST_ROTATE;
				end
			end
			r5dbr_pkg::ST_ROTATE: begin
				if (div_rsp.done) begin
					// block mod s, taken from block mod circle
					div_req.start    = 1'b1;
					div_req.dividend = DW'(r_q);
					div_req.divisor  = DW'(stripe_blocks_q);
					state_d          = r5dbr_pkg::ST_SUB;
				end
			end
			r5dbr_pkg::ST_SUB: begin
				if (div_rsp.done) begin
					// disk = (n - rotation + column) mod n
					div_req.start    = 1'b1;
					div_req.dividend = DW'(num_disks_q) - DW'(rot_q) + DW'(col_q);
					div_req.divisor  = DW'(num_disks_q);
					state_d          = r5dbr_pkg::ST_DISK;
				end
			end
			r5dbr_pkg::ST_DISK: begin
				if (div_rsp.done) begin
					state_d = r5dbr_pkg::ST_OFFSET;
				end
			end
			r5dbr_pkg::ST_OFFSET: begin
				state_d = r5dbr_pkg::ST_PLAN;
			end
			r5dbr_pkg::ST_PLAN: begin
				if (off_q >= {4'b0000, dwe_q}) begin
					fin     = 1'b1;
					state_d = r5dbr_pkg::ST_IDLE;
				end else if (pres_disk) begin
					rd_en   = 1'b1;
					state_d = r5dbr_pkg::ST_DRAIN;
				end else begin
					state_d = r5dbr_pkg::ST_WALK;
				end
			end
			r5dbr_pkg::ST_WALK: begin
				// rebuild: XOR over every present disk
				rd_en = pres_walk;
				if (walk_q == nm1) begin
					state_d = r5dbr_pkg::ST_DRAIN;
				end
			end
			r5dbr_pkg::ST_DRAIN: begin
				fin     = 1'b1;
				fin_ok  = 1'b1;
				state_d = r5dbr_pkg::ST_IDLE;
			end
			default: begin
				state_d = r5dbr_pkg::ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= r5dbr_pkg::ST_IDLE;
			take_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			take_s1 <= rd_en;
			done_q  <= fin;
		end
	end

	// query datapath captures
	always_ff @(posedge clk) begin
		case (state_q)
			r5dbr_pkg::ST_IDLE: begin
				if (accept) begin
					block_q <= block_number;
				end
			end
			r5dbr_pkg::ST_SETUP: begin
				cap_q    <= cap;
				circle_q <= circle;
				dwe_q    <= dwe;
				bad_q    <= n_bad || (missing > 5'd1);
			end
			r5dbr_pkg::ST_STRIPE: begin
				if (div_rsp.done) begin
					stripe_q <= div_rsp.quot[15:0];
					r_q      <= div_rsp.rem[15:0];
				end
			end
			r5dbr_pkg::ST_COLUMN: begin
				if (div_rsp.done) begin
					col_q <= div_rsp.quot[15:0];
				end
			end
			r5dbr_pkg::ST_ROTATE: begin
				if (div_rsp.done) begin
					rot_q <= div_rsp.rem[4:0];
				end
			end
			r5dbr_pkg::ST_SUB: begin
				if (div_rsp.done) begin
					sub_q <= div_rsp.rem[12:0];
				end
			end
			r5dbr_pkg::ST_DISK: begin
				if (div_rsp.done) begin
					disk_q <= div_rsp.rem[4:0];
				end
			end
			r5dbr_pkg::ST_OFFSET: begin
				off_q <= off_prod[16:0] + 17'(sub_q);
			end
			r5dbr_pkg::ST_PLAN: begin
				acc_q  <= 32'd0;
				walk_q <= 5'd0;
			end
			r5dbr_pkg::ST_WALK: begin
				acc_q  <= acc_d;
				walk_q <= walk_q + 5'd1;
			end
			default: ;
		endcase
	end

	// result registers
	always_ff @(posedge clk) begin
		if (fin) begin
			ok_q   <= fin_ok;
			data_q <= fin_ok ? acc_d : 32'd0;
		end
	end

	assign done = done_q;
	assign ok   = ok_q;
	assign data = data_q;

	// store addressing: loads in IDLE, reads during PLAN / WALK
	assign load_ok = accept && !kind && (32'(disk_index) < MAX_DISKS)
		&& (32'(word_offset) < WORDS_PER_DISK);
	assign rd_disk = (state_q == r5dbr_pkg::ST_PLAN) ? disk_q : walk_q;
	assign waddr   = AW'(disk_index) * AW'(WORDS_PER_DISK) + AW'(word_offset);
	assign raddr   = AW'(rd_disk) * AW'(WORDS_PER_DISK) + AW'(off_q);

	r5dbr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	r5dbr_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (load_ok),
		.re    (rd_en),
		.addr  (load_ok ? waddr : raddr),
		.wdata (load_word),
		.rdata (rdata)
	);

endmodule

/* design/r5dbr_chk.sv */
// ----------------------------------------------------------------------------
// r5dbr_chk
// Port-level checks on request/result sequencing, bound to the top level.
// ----------------------------------------------------------------------------
`include "raid5_degraded_block_read_assert.svh"

module r5dbr_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        kind,
	input logic        done,
	input logic        ok,
	input logic [31:0] data
);

	// failed queries report zero data
	`R5DBR_ASSERT_IMP(a_fail_zero, done && !ok, data == 32'd0)

	// a query request keeps the block busy
	`R5DBR_ASSERT_NXT(a_query_busy, start && !busy && kind, busy)

	// a load request never produces a result
	`R5DBR_ASSERT_NXT(a_load_silent, start && !busy && !kind, !done)

	// busy ends exactly when a result is shown
	`R5DBR_ASSERT_IMP(a_fell_done, $fell(busy), done)
	`R5DBR_ASSERT_IMP(a_done_idle, done, !busy)

endmodule

bind raid5_degraded_block_read r5dbr_chk u_r5dbr_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.kind   (kind),
	.done   (done),
	.ok     (ok),
	.data   (data)
);
